/* rtl/fed_pkg.sv */
// Shared types, constants and helpers for the feedback echo delay core.
// Depends on nothing; imported by feedback_echo_delay_core.
package fed_pkg;

    localparam int STORE_DEPTH = 1024;      // power of two, the address wraps on its own
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int DELAY_W     = 10;
    localparam int VOL_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int WIDE_W      = 19;        // headroom for every sum before saturation
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DELAY_W-1:0] DELAY_RESET  = DELAY_W'(600);
    localparam logic [VOL_W-1:0]   VOLUME_RESET = VOL_W'(32768);

    localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(32767);
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -WIDE_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_DEPTH = CFG_IDX_W'(0),
        CFG_VOLUME      = CFG_IDX_W'(1)
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       effect_on;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [7:0]                 pwm_high;
        logic [7:0]                 pwm_low;
    } t_out_beat;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAMPLE_W'(32767);
        end else if (v < SAT_MIN) begin
            r = -SAMPLE_W'(32768);
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/feedback_echo_delay_core.sv */
// Feedback echo with volume scaling and split PWM bytes; three-stage pipeline.
// Depends on fed_pkg for beat types, constants and the saturation helper.
// Data path: an accepted beat is registered in stage 1, then stage 2, then the output register on o_out.
// Throughput: one beat per cycle while i_out_stall is low; the store has one read and one write port,
// with a bypass for a read of the entry being written in the same cycle.
// Reset: synchronous active low; store reads as zero, write position zero,
// delay 600, volume 32768. No clearing pass: a fill count marks live entries.
module feedback_echo_delay_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  fed_pkg::t_in_beat            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output fed_pkg::t_out_beat           o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fed_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fed_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fed_pkg::*;

    // configuration
    logic [DELAY_W-1:0] r_delay;
    logic [VOL_W-1:0]   r_volume;

    // write side state
    logic [ADDR_W-1:0]  r_wp;
    logic [FILL_W-1:0]  r_fill;

    logic signed [SAMPLE_W-1:0] r_mem [STORE_DEPTH];

    // stage 1: input beat plus store read
    logic                       r_s1_vld;
    logic signed [SAMPLE_W-1:0] r_s1_x;
    logic                       r_s1_on;
    logic [ADDR_W-1:0]          r_s1_wp;
    logic                       r_s1_hit;
    logic                       r_s1_fwd;
    logic signed [SAMPLE_W-1:0] r_s1_fwd_data;
    logic signed [SAMPLE_W-1:0] r_s1_rd;

    // stage 2: echo result
    logic                       r_s2_vld;
    logic signed [SAMPLE_W-1:0] r_s2_echo;

    // output
    logic                       r_out_vld;
    t_out_beat                  r_out;

    logic out_ready, s2_ready, s1_ready, in_acc, s1_wr;
    logic [ADDR_W-1:0]          d_mod, rd_addr, back_dist;
    logic                       rd_hit, rd_fwd;
    logic signed [SAMPLE_W-1:0] delayed, fb_sat, echo;
    logic signed [WIDE_W-1:0]   fb_sum, fb_half, echo_sum;
    logic [SAMPLE_W-1:0]        offset_e;
    logic [2*VOL_W-1:0]         prod;
    logic signed [WIDE_W-1:0]   scaled;
    logic signed [SAMPLE_W-1:0] fin;
    logic [FILL_W-1:0]          n_fill;

    assign out_ready   = !r_out_vld || !i_out_stall;
    assign s2_ready    = !r_s2_vld || out_ready;
    assign s1_ready    = !r_s1_vld || s2_ready;
    assign in_acc      = i_in_valid && s1_ready;
    assign o_in_stall  = !s1_ready;
    assign o_cfg_ready = 1'b1;

    // Read address and liveness: the live entries are the r_fill positions just
    // below r_wp, so the read entry is live when its distance back fits the fill.
    always_comb begin
        d_mod     = ADDR_W'(r_delay);
        rd_addr   = r_wp - d_mod;
        back_dist = d_mod - ADDR_W'(1);
        rd_hit    = {1'b0, back_dist} < r_fill;
        rd_fwd    = s1_wr && (r_s1_wp == rd_addr);
        if (r_fill == FILL_W'(STORE_DEPTH)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    // Stage 1 arithmetic: feedback write and echo sum.
    always_comb begin
        if (!r_s1_hit) begin
            delayed = '0;
        end else if (r_s1_fwd) begin
            delayed = r_s1_fwd_data;
        end else begin
            delayed = r_s1_rd;
        end
        fb_sum = (WIDE_W'(r_s1_x) <<< 1) + WIDE_W'(delayed);
        // halve toward zero: bias negative sums up by one before the shift
        fb_half  = $signed(fb_sum + WIDE_W'(fb_sum[WIDE_W-1])) >>> 1;
        fb_sat   = sat16(fb_half);
        echo_sum = WIDE_W'(r_s1_x) + WIDE_W'(delayed);
        echo     = r_s1_on ? sat16(echo_sum) : r_s1_x;
    end

    assign s1_wr = r_s1_vld && r_s1_on && s2_ready;

    // Stage 2 arithmetic: ((e + 32768) * 2 * volume) >> 16 - volume.
    always_comb begin
        offset_e = {~r_s2_echo[SAMPLE_W-1], r_s2_echo[SAMPLE_W-2:0]};
        prod     = (2*VOL_W)'(offset_e) * (2*VOL_W)'(r_volume);
        scaled   = WIDE_W'({1'b0, prod[2*VOL_W-1:VOL_W-1]}) - WIDE_W'({1'b0, r_volume});
        fin      = sat16(scaled);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DELAY_RESET;
            r_volume <= VOLUME_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DELAY_DEPTH: r_delay  <= i_cfg_data[DELAY_W-1:0];
                CFG_VOLUME:      r_volume <= i_cfg_data[VOL_W-1:0];
                default: ;       // drop writes to unknown registers
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (in_acc) begin
            if (i_in.effect_on) begin
                r_wp   <= r_wp + ADDR_W'(1);
                r_fill <= n_fill;
            end else begin
                r_wp   <= ADDR_W'(1);
                r_fill <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_mem[r_s1_wp] <= fb_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x        <= i_in.sample_in;
            r_s1_on       <= i_in.effect_on;
            r_s1_wp       <= r_wp;
            r_s1_hit      <= rd_hit;
            r_s1_fwd      <= rd_fwd;
            r_s1_fwd_data <= fb_sat;
        end
        if (r_s1_vld && s2_ready) begin
            r_s2_echo <= echo;
        end
        if (r_s2_vld && out_ready) begin
            r_out.sample_out <= fin;
            r_out.pwm_high   <= {~fin[SAMPLE_W-1], fin[SAMPLE_W-2:8]};
            r_out.pwm_low    <= fin[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_vld <= r_s1_vld;
            end
            if (out_ready) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_bypass_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in.effect_on |=> r_wp == ADDR_W'(1) && r_fill == '0)
        else $error("bypass beat did not clear the store");

    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && s2_ready |=> r_s2_vld)
        else $error("stage 1 beat lost on advance");

    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && rd_fwd |=> r_s1_hit)
        else $error("bypassed entry not counted live");

endmodule

/* dv/feedback_echo_delay_core_test.sv */
// Self-checking testbench for feedback_echo_delay_core: directed and random sample beats,
// register writes between phases and random idling on both channels.
// Depends on fed_pkg and the core RTL; an internal echo tracker predicts every result beat.
module feedback_echo_delay_core_test;
    import fed_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int REG_COUNT       = 2;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 206;
    localparam int NOISE_PHASE     = PHASES - 1;

    // Tracks the echo store, write position and registers; queues the expected beats.
    class echo_tracker;
        logic signed [SAMPLE_W-1:0] echo_mem [STORE_DEPTH];
        bit                         live [STORE_DEPTH];
        logic [ADDR_W-1:0]          wr_pos;
        logic [DELAY_W-1:0]         depth;
        logic [VOL_W-1:0]           vol;
        t_out_beat                  expected_beats [$];
        int                         fail_count;

        function new();
            foreach (echo_mem[i]) begin
                echo_mem[i] = '0;
                live[i] = 1'b0;
            end
            wr_pos = '0;
            depth = DELAY_RESET;
            vol = VOLUME_RESET;
            fail_count = 0;
        endfunction

        function logic signed [SAMPLE_W-1:0] clamp16(longint v);
            logic signed [SAMPLE_W-1:0] r;
            if (v > 32767) begin
                r = 16'sh7FFF;
            end else if (v < -32768) begin
                r = 16'sh8000;
            end else begin
                r = v[SAMPLE_W-1:0];
            end
            return r;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DELAY_DEPTH: depth = data[DELAY_W-1:0];
                CFG_VOLUME:      vol = data[VOL_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_sample(t_in_beat b);
            int                         x;
            int                         delayed;
            int                         fb;
            longint                     scaled;
            logic [ADDR_W-1:0]          rd_pos;
            logic signed [SAMPLE_W-1:0] echo;
            logic signed [SAMPLE_W-1:0] fin;
            logic [SAMPLE_W-1:0]        biased;
            t_out_beat                  r;
            x = int'(b.sample_in);
            if (b.effect_on) begin
                // read before write, so a zero delay sees the entry about to be replaced
                rd_pos = wr_pos - depth;
                delayed = live[rd_pos] ? int'(echo_mem[rd_pos]) : 0;
                fb = (2 * x + delayed) / 2;
                echo_mem[wr_pos] = clamp16(fb);
                live[wr_pos] = 1'b1;
                echo = clamp16(x + delayed);
            end else begin
                echo = b.sample_in;
                foreach (live[i]) live[i] = 1'b0;
                wr_pos = '0;
            end
            wr_pos = wr_pos + 1'b1;
            scaled = ((longint'(echo) + 32768) * 2 * longint'(vol)) / 65536 - longint'(vol);
            fin = clamp16(scaled);
            biased = fin + 16'h8000;
            r.sample_out = fin;
            r.pwm_high = biased[15:8];
            r.pwm_low = fin[7:0];
            expected_beats.push_back(r);
        endfunction

        function void compare_beat(t_out_beat got);
            t_out_beat want;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: sample_out %0d", got.sample_out);
                fail_count++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.sample_out !== want.sample_out) begin
                $error("sample_out: expected %0d, actual %0d", want.sample_out, got.sample_out);
                fail_count++;
            end
            if (got.pwm_high !== want.pwm_high) begin
                $error("pwm_high: expected %0d, actual %0d", want.pwm_high, got.pwm_high);
                fail_count++;
            end
            if (got.pwm_low !== want.pwm_low) begin
                $error("pwm_low: expected %0d, actual %0d", want.pwm_low, got.pwm_low);
                fail_count++;
            end
        endfunction

        function int outstanding();
            return expected_beats.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_beat               i_in;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_beat              o_out;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    echo_tracker tracker;
    bit          idle_on;
    int          stall_left;
    int          cycle_count;

    feedback_echo_delay_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.apply_reg(i_cfg_index, i_cfg_data);
            end
            // predict first: a beat accepted now can never be the one leaving now
            if (i_in_valid && !o_in_stall) begin
                tracker.accept_sample(i_in);
            end
            if (o_out_valid && !i_out_stall) begin
                tracker.compare_beat(o_out);
            end
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("feedback_echo_delay_core_test failed");
            $finish;
        end
    end

    // Stall the result channel in random bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] r;
        case ($urandom_range(0, 9))
            0:       r = 16'sh7FFF;
            1:       r = 16'sh8000;
            2:       r = SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
            default: r = SAMPLE_W'($urandom);
        endcase
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic on);
        int       gap;
        t_in_beat b;
        b.sample_in = s;
        b.effect_on = on;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Only call with nothing in flight.
    task automatic set_phase_regs(input logic [CFG_DATA_W-1:0] depth_word,
                                  input logic [CFG_DATA_W-1:0] vol_word,
                                  input bit stray);
        program_reg(CFG_DELAY_DEPTH, depth_word);
        program_reg(CFG_VOLUME, vol_word);
        if (stray) begin
            program_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
                        CFG_DATA_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] depth_word;
        logic [CFG_DATA_W-1:0] vol_word;
        int                    off_odds;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_on = 1'b1;
        stall_left = 0;
        cycle_count = 0;
        tracker = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: long delay, full volume
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b1);
        drain_results();

        // one-sample delay: saturating feedback, truncation of an odd echo, clear
        set_phase_regs(16'd1, 16'd32768, 1'b0);
        repeat (3) send_sample(16'sh7FFF, 1'b1);
        repeat (3) send_sample(16'sh8000, 1'b1);
        send_sample(-16'sd3, 1'b1);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd5, 1'b1);
        drain_results();

        // delay wraps to zero, volume past the nominal limit, stray register index
        set_phase_regs(16'h0400, 16'hFFFF, 1'b1);
        send_sample(16'sd100, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(-16'sd1, 1'b0);
        drain_results();

        // deepest delay, volume zero
        set_phase_regs(16'hFFFF, 16'h0000, 1'b1);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sd7, 1'b1);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            idle_on = (p != PHASES - 1);
            case (p)
                0:       depth_word = {6'($urandom), 10'($urandom_range(1, 8))};
                1:       depth_word = {6'($urandom), 10'd1};
                5:       depth_word = {6'($urandom), 10'd1023};
                6:       depth_word = {6'($urandom), 10'd0};
                default: depth_word = $urandom_range(0, 1) ? CFG_DATA_W'($urandom)
                                    : {6'($urandom), 10'($urandom_range(1, 40))};
            endcase
            case (p)
                0:       vol_word = 16'd32768;
                1:       vol_word = 16'hFFFF;
                2:       vol_word = 16'd0;
                3:       vol_word = 16'($urandom_range(0, 32768));
                default: vol_word = 16'($urandom);
            endcase
            set_phase_regs(depth_word, vol_word, $urandom_range(0, 1));
            // long runs with the effect on fill the store; the last phase clears often
            off_odds = (p == NOISE_PHASE) ? 8 : 2000;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_sample(pick_sample(), $urandom_range(0, off_odds - 1) != 0);
            end
            drain_results();
        end

        if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
            $display("feedback_echo_delay_core_test passed");
        end else begin
            $display("feedback_echo_delay_core_test failed");
        end
        $finish;
    end

endmodule
